// ===== rtl/tdma_beacon_slot_scheduler_core_macros.svh =====
// Assertion macros shared by the slot scheduler modules.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef TDMA_BEACON_SLOT_SCHEDULER_CORE_MACROS_SVH
`define TDMA_BEACON_SLOT_SCHEDULER_CORE_MACROS_SVH

// implication checked on the same edge
`define TBSS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tbss check failed");

// implication checked on the following edge
`define TBSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tbss check failed");

`endif

// ===== rtl/tbss_pkg.sv =====
// Types and constants of the slot scheduler.
// No dependencies; used by every module of the block.
package tbss_pkg;

    localparam int unsigned DIV_STAGES  = 48;
    localparam int unsigned HI_STAGES   = 32;
    localparam int unsigned FIFO_DEPTH  = 4;
    localparam logic [7:0]  NO_NODE     = 8'hFF;

    typedef enum logic [1:0] {
        REG_NODE_COUNT = 2'd0,
        REG_LOCAL_NODE = 2'd1,
        REG_MINISLOTS  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] n;
        logic [7:0] l;
        logic [7:0] mm;
    } cfg_t;

    typedef struct packed {
        logic [31:0] k;
        logic [7:0]  m;
        logic [7:0]  r;
        logic [7:0]  o;
        logic [7:0]  rank;
    } qry_t;

    typedef struct packed {
        logic n_zero;
        logic turn_bad;
        logic mini_bad;
        logic ord_bad;
    } flags_t;

    typedef struct packed {
        qry_t   q;
        flags_t f;
    } entry_t;

    typedef struct packed {
        logic [7:0]  tx;
        logic [7:0]  turns;
        logic [7:0]  mini;
        logic [31:0] idx;
        logic [7:0]  delta;
        logic [7:0]  order;
    } res_t;

endpackage

// ===== rtl/tdma_beacon_slot_scheduler_core.sv =====
// Round-robin TDMA slot scheduler, top level.
// Path from input accept to result accept: front register, queue, divider
// pipeline, schedule math register, output register. Throughput: one word per
// cycle while m_tready does not stall the output, set by the 48-stage bit-serial divider pipeline.
// Reset: synchronous active-low aresetn clears configuration and all valids.
module tdma_beacon_slot_scheduler_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // superslot[31:0], minislot[39:32], reporter[47:40], observed[55:48], rank[63:56]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // transmitter[7:0], turns_until_owner[15:8], minislots_until_owner[23:16],
    // slot_index[55:24], round_delta[63:56], order_node[71:64]
    output logic [71:0] m_tdata
);
    import tbss_pkg::*;

    cfg_t   cfg_reg;
    qry_t   q;
    entry_t f_ent, b_ent;
    logic   push, full, pop, empty;
    res_t   res;

    assign q.k    = s_tdata[31:0];
    assign q.m    = s_tdata[39:32];
    assign q.r    = s_tdata[47:40];
    assign q.o    = s_tdata[55:48];
    assign q.rank = s_tdata[63:56];

    assign m_tdata = {res.order, res.delta, res.idx, res.mini, res.turns, res.tx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_idx))
                REG_NODE_COUNT: cfg_reg.n  <= cfg_wdata;
                REG_LOCAL_NODE: cfg_reg.l  <= cfg_wdata;
                REG_MINISLOTS:  cfg_reg.mm <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tbss_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_q     (q),
        .push     (push),
        .full     (full),
        .ent      (f_ent)
    );

    tbss_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (f_ent),
        .full    (full),
        .pop     (pop),
        .empty   (empty),
        .dout    (b_ent)
    );

    tbss_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .empty     (empty),
        .din       (b_ent),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res)
    );
endmodule

// ===== rtl/tbss_fifo.sv =====
// Short queue between front and back parts.
// Depends on tbss_pkg and the macros header.
module tbss_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tbss_pkg::entry_t din,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output tbss_pkg::entry_t dout
);
    import tbss_pkg::*;
    `include "tdma_beacon_slot_scheduler_core_macros.svh"

    localparam int unsigned AW = $clog2(FIFO_DEPTH);

    entry_t         mem_reg [FIFO_DEPTH];
    logic [AW-1:0]  wr_reg, rd_reg;
    logic [AW:0]    cnt_reg, cnt_next;

    assign full  = (cnt_reg == (AW+1)'(FIFO_DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_reg] <= din;
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    `TBSS_ASSERT_NOW(a_no_overflow, push, !full)
    `TBSS_ASSERT_NOW(a_no_underflow, pop, !empty)
    `TBSS_ASSERT_NEXT(a_cnt_step, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)
endmodule

// ===== rtl/tbss_front.sv =====
// Front part: accept query words and classify them against the configuration.
// Depends on tbss_pkg.
module tbss_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  tbss_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  tbss_pkg::qry_t   in_q,
    output logic             push,
    input  logic             full,
    output tbss_pkg::entry_t ent
);
    import tbss_pkg::*;

    entry_t ent_reg, ent_next;
    logic   v_reg;

    assign push     = v_reg && !full;
    assign in_ready = !v_reg || !full;
    assign ent      = ent_reg;

    always_comb begin
        ent_next            = ent_reg;
        ent_next.q          = in_q;
        ent_next.f.n_zero   = (cfg.n == 8'd0);
        ent_next.f.turn_bad = (cfg.n == 8'd0) || (cfg.l >= cfg.n);
        ent_next.f.mini_bad = (cfg.mm == 8'd0) || (in_q.m >= cfg.mm);
        ent_next.f.ord_bad  = (cfg.n < 8'd2) || (in_q.r >= cfg.n)
                              || ({1'b0, in_q.rank} >= ({1'b0, cfg.n} - 9'd1));
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready)
            ent_reg <= ent_next;
        if (!aresetn)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end
endmodule

// ===== rtl/tbss_back.sv =====
// Back part: pipelined divider (k by N*N, then remainder by N), schedule math,
// output register. Depends on tbss_pkg and the macros header.
module tbss_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  tbss_pkg::cfg_t   cfg,
    input  logic             empty,
    input  tbss_pkg::entry_t din,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output tbss_pkg::res_t   res
);
    import tbss_pkg::*;
    `include "tdma_beacon_slot_scheduler_core_macros.svh"

    typedef struct packed {
        entry_t      e;
        logic [16:0] rem;
        logic [15:0] rr;
        logic [7:0]  qn;
        logic [7:0]  rrem;
        logic [7:0]  orem;
    } st_t;

    typedef struct packed {
        logic [7:0]  tx;
        logic [7:0]  turns;
        logic [31:0] idx;
        logic [7:0]  delta;
        logic [7:0]  order;
        logic [7:0]  m;
        logic        mini_bad;
    } a_t;

    st_t         st_reg [DIV_STAGES+1];
    st_t         st_next [DIV_STAGES];
    logic        v_reg [DIV_STAGES+1];
    a_t          a_reg, a_next;
    logic        a_v_reg;
    res_t        o_reg, o_next;
    logic        o_v_reg;
    logic        en;
    logic [15:0] nsq;
    st_t         s0;

    assign en        = !o_v_reg || out_ready;
    assign pop       = en && !empty;
    assign out_valid = o_v_reg;
    assign res       = o_reg;
    assign nsq       = 16'(cfg.n) * 16'(cfg.n);

    always_comb begin
        s0      = '0;
        s0.e    = din;
    end

    always_comb begin
        logic [16:0] tmp;
        logic [16:0] dv;
        logic [8:0]  lt;
        logic        ge;
        for (int i = 0; i < DIV_STAGES; i++) begin
            st_next[i] = st_reg[i];
            if (i < HI_STAGES) begin
                tmp = {st_reg[i].rem[15:0], st_reg[i].e.q.k[5'(31 - i)]};
                dv  = {1'b0, nsq};
            end else begin
                tmp = {st_reg[i].rem[15:0], st_reg[i].rr[4'(47 - i)]};
                dv  = 17'(cfg.n);
            end
            ge = (tmp >= dv);
            st_next[i].rem = ge ? (tmp - dv) : tmp;
            if (i >= HI_STAGES)
                st_next[i].qn = {st_reg[i].qn[6:0], ge};
            if (i == HI_STAGES - 1) begin
                st_next[i].rr  = st_next[i].rem[15:0];
                st_next[i].rem = '0;
            end
            if (i < 8) begin
                lt = {st_reg[i].rrem, st_reg[i].e.q.r[3'(7 - i)]};
                st_next[i].rrem = (lt >= {1'b0, cfg.n}) ? 8'(lt - {1'b0, cfg.n}) : lt[7:0];
                lt = {st_reg[i].orem, st_reg[i].e.q.o[3'(7 - i)]};
                st_next[i].orem = (lt >= {1'b0, cfg.n}) ? 8'(lt - {1'b0, cfg.n}) : lt[7:0];
            end
        end
    end

    always_comb begin
        st_t        s;
        logic [7:0] tv;
        logic [9:0] d10;
        logic [8:0] s1;
        logic [8:0] w;
        logic [9:0] s2;
        logic [8:0] dd;
        logic [8:0] st9;
        logic [8:0] p9;
        logic [8:0] c9;
        logic [8:0] nd;
        s   = st_reg[DIV_STAGES];
        tv  = s.rem[7:0];
        d10 = {2'b0, cfg.l} - {2'b0, tv} - 10'd1;
        if (d10[9])
            d10 = d10 + {2'b0, cfg.n};
        s1 = d10[8:0] + 9'd1;
        w  = 9'd256 - {1'b0, s.e.q.k[7:0]};
        s2 = {1'b0, w} + {2'b0, cfg.l};
        a_next.turns = s1[7:0];
        if ((&s.e.q.k[31:8]) && (s1 >= w))
            a_next.turns = (s2 <= {2'b0, cfg.n}) ? s2[7:0] : 8'd0;
        if (s.e.f.turn_bad)
            a_next.turns = 8'd0;
        a_next.tx = s.e.f.n_zero ? 8'd0 : tv;
        dd = {1'b0, s.rrem} - {1'b0, s.orem};
        if (dd[8])
            dd = dd + {1'b0, cfg.n};
        a_next.delta = s.e.f.n_zero ? 8'd0 : dd[7:0];
        st9 = {1'b0, s.qn} + 9'd1;
        if (st9 == {1'b0, cfg.n})
            st9 = '0;
        p9 = {1'b0, s.e.q.r} - st9;
        if (p9[8])
            p9 = p9 + {1'b0, cfg.n};
        c9 = (s.e.q.rank < p9[7:0]) ? {1'b0, s.e.q.rank} : ({1'b0, s.e.q.rank} + 9'd1);
        nd = st9 + c9;
        if (nd >= {1'b0, cfg.n})
            nd = nd - {1'b0, cfg.n};
        a_next.order    = s.e.f.ord_bad ? NO_NODE : nd[7:0];
        a_next.idx      = s.e.q.k * {24'd0, cfg.mm} + {24'd0, s.e.q.m};
        a_next.m        = s.e.q.m;
        a_next.mini_bad = s.e.f.mini_bad;
    end

    always_comb begin
        logic [15:0] pr;
        pr             = {8'd0, a_reg.turns} * {8'd0, cfg.mm};
        o_next.tx      = a_reg.tx;
        o_next.turns   = a_reg.turns;
        o_next.idx     = a_reg.idx;
        o_next.delta   = a_reg.delta;
        o_next.order   = a_reg.order;
        o_next.mini    = (a_reg.mini_bad || a_reg.turns == 8'd0) ? 8'd0
                         : (pr[7:0] - a_reg.m);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= s0;
            for (int i = 0; i < DIV_STAGES; i++)
                st_reg[i+1] <= st_next[i];
            a_reg <= a_next;
            o_reg <= o_next;
        end
        if (!aresetn) begin
            for (int i = 0; i <= DIV_STAGES; i++)
                v_reg[i] <= 1'b0;
            a_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end else if (en) begin
            v_reg[0] <= !empty;
            for (int i = 0; i < DIV_STAGES; i++)
                v_reg[i+1] <= v_reg[i];
            a_v_reg <= v_reg[DIV_STAGES];
            o_v_reg <= a_v_reg;
        end
    end

    `TBSS_ASSERT_NOW(a_zero_n, o_v_reg && cfg.n == 8'd0,
        o_reg.order == NO_NODE && o_reg.turns == 8'd0 && o_reg.tx == 8'd0)
    `TBSS_ASSERT_NOW(a_turns_range, o_v_reg, o_reg.turns <= cfg.n)
    `TBSS_ASSERT_NOW(a_mini_zero, o_v_reg && o_reg.turns == 8'd0, o_reg.mini == 8'd0)
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the TDMA beacon slot scheduler core.
// Drives random and corner queries over several register settings and checks every result word.
// Depends on tbss_pkg and tdma_beacon_slot_scheduler_core.
module testbench;
    import tbss_pkg::*;

    typedef struct packed {
        logic [7:0]  rank;
        logic [7:0]  o;
        logic [7:0]  r;
        logic [7:0]  m;
        logic [31:0] k;
    } query_t;

    typedef struct packed {
        logic [7:0]  order;
        logic [7:0]  delta;
        logic [31:0] idx;
        logic [7:0]  mini;
        logic [7:0]  turns;
        logic [7:0]  tx;
    } answer_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    logic [7:0] sched_n;
    logic [7:0] sched_local;
    logic [7:0] sched_mini;

    query_t  pending_words[$];
    answer_t expected_answers[$];
    int      fail_count;
    int      words_sent;
    int      words_seen;
    int      idle_cycles;
    int      s_gap;
    int      m_gap;
    bit      gaps_on;

    tdma_beacon_slot_scheduler_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic answer_t schedule_answer(query_t q);
        answer_t a;
        int unsigned n;
        int unsigned mm;
        int unsigned start;
        int unsigned seen;
        int unsigned node;
        logic [31:0] t;
        n = sched_n;
        mm = sched_mini;
        a = '0;
        a.order = NO_NODE;
        if (n != 0) begin
            a.tx = 8'(q.k % n);
            a.delta = 8'(((q.r % n) + n - (q.o % n)) % n);
            if (sched_local < n) begin
                for (int s = 1; s <= n; s++) begin
                    t = q.k + s;
                    if (t % n == sched_local) begin
                        a.turns = 8'(s);
                        break;
                    end
                end
            end
            if (n >= 2 && q.rank < n - 1 && q.r < n) begin
                start = ((q.k / n) + 1) % n;
                seen = 0;
                for (int c = 0; c < n; c++) begin
                    node = (start + c) % n;
                    if (node == q.r) continue;
                    if (seen == q.rank) begin
                        a.order = 8'(node);
                        break;
                    end
                    seen++;
                end
            end
        end
        if (mm != 0 && q.m < mm && a.turns != 0)
            a.mini = 8'(a.turns * mm - q.m);
        a.idx = 32'(q.k * mm + q.m);
        return a;
    endfunction

    function automatic query_t random_query();
        query_t q;
        int unsigned n;
        n = (sched_n == 0) ? 1 : sched_n;
        q.k = $urandom();
        case ($urandom_range(3))
            0: q.k = 32'hFFFF_FFFF - $urandom_range(300);
            1: q.k = $urandom_range(600);
            default: ;
        endcase
        q.m = 8'($urandom_range(2) == 0 ? $urandom() : $urandom_range(sched_mini));
        q.r = 8'($urandom_range(3) == 0 ? $urandom() : $urandom_range(n - 1));
        q.o = 8'($urandom());
        q.rank = 8'($urandom_range(3) == 0 ? $urandom() : $urandom_range(n));
        return q;
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [7:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_NODE_COUNT: sched_n = value;
            REG_LOCAL_NODE: sched_local = value;
            default:        sched_mini = value;
        endcase
    endtask

    task automatic wait_idle();
        wait (pending_words.size() == 0 && expected_answers.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
        end else if (s_gap > 0) begin
            s_gap <= s_gap - 1;
            s_tvalid <= 1'b0;
        end else if (pending_words.size() != 0) begin
            s_tdata <= pending_words.pop_front();
            s_tvalid <= 1'b1;
            if (gaps_on && $urandom_range(7) == 0) s_gap <= $urandom_range(1, 6);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (gaps_on && aresetn && $urandom_range(7) == 0) m_gap <= $urandom_range(1, 6);
        end
    end

    // monitor
    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        bit      moved;
        if (aresetn) begin
            moved = 1'b0;
            if (s_tvalid && s_tready) begin
                expected_answers.push_back(schedule_answer(query_t'(s_tdata)));
                words_sent <= words_sent + 1;
                moved = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                words_seen <= words_seen + 1;
                got = m_tdata;
                if (expected_answers.size() == 0) begin
                    $error("unexpected word %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_answers.pop_front();
                    if (got.tx !== want.tx) begin
                        $error("transmitter exp %0d got %0d", want.tx, got.tx);
                        fail_count++;
                    end
                    if (got.turns !== want.turns) begin
                        $error("turns_until_owner exp %0d got %0d", want.turns, got.turns);
                        fail_count++;
                    end
                    if (got.mini !== want.mini) begin
                        $error("minislots_until_owner exp %0d got %0d", want.mini, got.mini);
                        fail_count++;
                    end
                    if (got.idx !== want.idx) begin
                        $error("slot_index exp %0d got %0d", want.idx, got.idx);
                        fail_count++;
                    end
                    if (got.delta !== want.delta) begin
                        $error("round_delta exp %0d got %0d", want.delta, got.delta);
                        fail_count++;
                    end
                    if (got.order !== want.order) begin
                        $error("order_node exp %0d got %0d", want.order, got.order);
                        fail_count++;
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        query_t q;
        logic [7:0] settings [7][3];
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_NODE_COUNT;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        sched_n = 0;
        sched_local = 0;
        sched_mini = 0;
        fail_count = 0;
        words_sent = 0;
        words_seen = 0;
        idle_cycles = 0;
        s_gap = 0;
        m_gap = 0;
        gaps_on = 1'b1;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset values first, then directed corners
        for (int i = 0; i < 4; i++) begin
            q = '0;
            q.k = (i == 1) ? 32'hFFFF_FFFF : 32'd0;
            q.m = (i == 2) ? 8'hFF : 8'd0;
            q.r = (i == 3) ? 8'hFF : 8'd0;
            q.o = (i == 3) ? 8'hFF : 8'd0;
            q.rank = (i == 3) ? 8'hFF : 8'd0;
            pending_words.push_back(q);
        end
        wait_idle();

        settings = '{'{8'd5, 8'd2, 8'd4}, '{8'd255, 8'd254, 8'd255},
                     '{8'd1, 8'd0, 8'd1}, '{8'd2, 8'd1, 8'd255},
                     '{8'd7, 8'd9, 8'd3}, '{8'd0, 8'd0, 8'd10},
                     '{8'd200, 8'd17, 8'd0}};
        write_reg(REG_NODE_COUNT, 8'd3);
        write_reg(REG_LOCAL_NODE, 8'd1);
        write_reg(REG_MINISLOTS, 8'd4);
        for (int i = 0; i < 20; i++) begin
            q.k = (i < 10) ? 32'hFFFF_FFFF - 32'(i) : 32'(i);
            q.m = (i % 5 == 4) ? 8'd4 : 8'(i % 4);
            q.r = 8'(i % 4);
            q.o = 8'(8'hFF - i);
            q.rank = 8'(i % 3);
            pending_words.push_back(q);
        end
        wait_idle();

        for (int p = 0; p < 7; p++) begin
            write_reg(REG_NODE_COUNT, settings[p][0]);
            write_reg(REG_LOCAL_NODE, settings[p][1]);
            write_reg(REG_MINISLOTS, settings[p][2]);
            if (p == 6) gaps_on = 1'b0;
            for (int i = 0; i < 215; i++) pending_words.push_back(random_query());
            wait_idle();
        end

        $display("Covered %0d query words over 9 register settings, %0d results checked.",
                 words_sent, words_seen);
        if (fail_count == 0 && expected_answers.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tbss_pkg.sv
rtl/tbss_fifo.sv
rtl/tbss_front.sv
rtl/tbss_back.sv
rtl/tdma_beacon_slot_scheduler_core.sv
verif/testbench.sv
